### hw/rtl/hsvrgb_pkg.sv
// Shared types and sector codes for the HSV to RGB converter.
`default_nettype none

package hsvrgb_pkg;

    typedef logic [2:0] t_sector;

    localparam t_sector SECT_0 = 3'd0;
    localparam t_sector SECT_1 = 3'd1;
    localparam t_sector SECT_2 = 3'd2;
    localparam t_sector SECT_3 = 3'd3;
    localparam t_sector SECT_4 = 3'd4;
    localparam t_sector SECT_5 = 3'd5;
    localparam t_sector SECT_WRAP = 3'd6;

    localparam int unsigned CHAN_W = 8;

endpackage

`default_nettype wire

### hw/rtl/hsv_to_rgb_converter_unit.sv
// Top level of the HSV to RGB converter: four-stage six-sector pipeline.
//
// Takes one pixel per clock: a beat is accepted whenever start is high, and busy is
// always low since nothing ever holds the pipeline. Each result appears on o_red,
// o_green and o_blue with o_valid high for one cycle, once it has passed the stage 0
// to 3 registers; the receiver cannot stall. The stages are: clamp and hue times six; the
// s*f, s*(1-f) and v*(1-s) multipliers; the v*(1-sf) and v*(1-sfc) multipliers;
// sector mix and scaling to 8 bits. Inputs above 1.0 are clamped to 1.0, and a hue of
// exactly 1.0 wraps to sector 0.
`default_nettype none

module hsv_to_rgb_converter_unit
    import hsvrgb_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [FRAC_BITS:0]   i_hue,
    input  wire logic [FRAC_BITS:0]   i_saturation,
    input  wire logic [FRAC_BITS:0]   i_brightness,
    output logic                      o_valid,
    output logic [CHAN_W-1:0]         o_red,
    output logic [CHAN_W-1:0]         o_green,
    output logic [CHAN_W-1:0]         o_blue
);

    localparam int unsigned F = FRAC_BITS;
    localparam int unsigned W = FRAC_BITS + 1;
    localparam int unsigned PW = 2 * W;
    localparam int unsigned HW = W + 3;
    localparam int unsigned BW = W + CHAN_W;
    localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};

    // stage 0: clamp, hue times six
    logic [W-1:0]  n_hue, n_sat, n_val;
    logic [HW-1:0] n_h;
    t_sector       n_sect;

    logic          r_s0_vld;
    t_sector       r_s0_sect;
    logic [F-1:0]  r_s0_f;
    logic [W-1:0]  r_s0_sat;
    logic [W-1:0]  r_s0_val;

    assign busy = 1'b0;

    always_comb begin
        n_hue = (i_hue > ONE) ? ONE : i_hue;
        n_sat = (i_saturation > ONE) ? ONE : i_saturation;
        n_val = (i_brightness > ONE) ? ONE : i_brightness;
        n_h   = {1'b0, n_hue, 2'b00} + {2'b00, n_hue, 1'b0};
        n_sect = n_h[F+2:F];
        if (n_sect == SECT_WRAP) begin
            n_sect = SECT_0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_sect <= n_sect;
        r_s0_f    <= n_h[F-1:0];
        r_s0_sat  <= n_sat;
        r_s0_val  <= n_val;
    end

    // stage 1: s*f, s*(1-f), v*(1-s)
    logic [PW-1:0] n_m_sf, n_m_sfc, n_m_p;

    logic          r_s1_vld;
    t_sector       r_s1_sect;
    logic [W-1:0]  r_s1_sf;
    logic [W-1:0]  r_s1_sfc;
    logic [W-1:0]  r_s1_p;
    logic [W-1:0]  r_s1_val;

    always_comb begin
        n_m_sf  = PW'(r_s0_sat) * PW'({1'b0, r_s0_f});
        n_m_sfc = PW'(r_s0_sat) * PW'(ONE - {1'b0, r_s0_f});
        n_m_p   = PW'(r_s0_val) * PW'(ONE - r_s0_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sect <= r_s0_sect;
        r_s1_sf   <= n_m_sf[2*F:F];
        r_s1_sfc  <= n_m_sfc[2*F:F];
        r_s1_p    <= n_m_p[2*F:F];
        r_s1_val  <= r_s0_val;
    end

    // stage 2: v*(1-sf), v*(1-sfc)
    logic [PW-1:0] n_m_q, n_m_t;

    logic          r_s2_vld;
    t_sector       r_s2_sect;
    logic [W-1:0]  r_s2_p;
    logic [W-1:0]  r_s2_q;
    logic [W-1:0]  r_s2_t;
    logic [W-1:0]  r_s2_val;

    always_comb begin
        n_m_q = PW'(r_s1_val) * PW'(ONE - r_s1_sf);
        n_m_t = PW'(r_s1_val) * PW'(ONE - r_s1_sfc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_sect <= r_s1_sect;
        r_s2_p    <= r_s1_p;
        r_s2_q    <= n_m_q[2*F:F];
        r_s2_t    <= n_m_t[2*F:F];
        r_s2_val  <= r_s1_val;
    end

    // stage 3: sector mix, scale by 255
    logic [W-1:0]  n_r, n_g, n_b;
    logic [BW-1:0] n_r255, n_g255, n_b255;

    logic          r_s3_vld;
    logic [CHAN_W-1:0] r_red, r_green, r_blue;

    always_comb begin
        unique case (r_s2_sect)
            SECT_0: begin
                n_r = r_s2_val; n_g = r_s2_t;   n_b = r_s2_p;
            end
            SECT_1: begin
                n_r = r_s2_q;   n_g = r_s2_val; n_b = r_s2_p;
            end
            SECT_2: begin
                n_r = r_s2_p;   n_g = r_s2_val; n_b = r_s2_t;
            end
            SECT_3: begin
                n_r = r_s2_p;   n_g = r_s2_q;   n_b = r_s2_val;
            end
            SECT_4: begin
                n_r = r_s2_t;   n_g = r_s2_p;   n_b = r_s2_val;
            end
            default: begin
                n_r = r_s2_val; n_g = r_s2_p;   n_b = r_s2_q;
            end
        endcase
        n_r255 = {n_r, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, n_r};
        n_g255 = {n_g, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, n_g};
        n_b255 = {n_b, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, n_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_r255[F+CHAN_W-1:F];
        r_green <= n_g255[F+CHAN_W-1:F];
        r_blue  <= n_b255[F+CHAN_W-1:F];
    end

    assign o_valid = r_s3_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

### tb/hsv_to_rgb_converter_unit_tb.sv
// Self-checking testbench for the HSV to RGB converter pipeline.
`default_nettype none

module hsv_to_rgb_converter_unit_tb
    import hsvrgb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC_BITS = 16;
    localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_PIXELS = 1400;
    localparam longint unsigned CYCLE_LIMIT = 200000;

    typedef logic [FRAC_BITS:0] t_fraction;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_fraction         i_hue;
    t_fraction         i_saturation;
    t_fraction         i_brightness;
    logic              o_valid;
    logic [CHAN_W-1:0] o_red;
    logic [CHAN_W-1:0] o_green;
    logic [CHAN_W-1:0] o_blue;

    t_rgb            pending_rgb[$];
    int unsigned     err_count = 0;
    longint unsigned cycle_count = 0;

    hsv_to_rgb_converter_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_hue(i_hue),
        .i_saturation(i_saturation),
        .i_brightness(i_brightness),
        .o_valid(o_valid),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint unsigned clamp_fraction(input t_fraction x);
        return (longint'(x) > ONE) ? ONE : longint'(x);
    endfunction

    function automatic logic [CHAN_W-1:0] to_channel(input longint unsigned comp);
        longint unsigned scaled;
        scaled = (comp * 255) >> FRAC_BITS;
        return scaled[CHAN_W-1:0];
    endfunction

    function automatic t_rgb predict_rgb(input t_fraction hue_in, input t_fraction sat_in,
                                         input t_fraction val_in);
        longint unsigned hue, sat, val, h6, frac, sf, sfc, p, q, t;
        longint unsigned r, g, b;
        t_sector         sector;
        t_rgb            rgb;
        hue = clamp_fraction(hue_in);
        sat = clamp_fraction(sat_in);
        val = clamp_fraction(val_in);
        h6 = hue * 6;
        sector = t_sector'((h6 >> FRAC_BITS) % 6);
        frac = h6 & (ONE - 1);
        sf = (sat * frac) >> FRAC_BITS;
        sfc = (sat * (ONE - frac)) >> FRAC_BITS;
        p = (val * (ONE - sat)) >> FRAC_BITS;
        q = (val * (ONE - sf)) >> FRAC_BITS;
        t = (val * (ONE - sfc)) >> FRAC_BITS;
        case (sector)
            SECT_0: begin r = val; g = t;   b = p;   end
            SECT_1: begin r = q;   g = val; b = p;   end
            SECT_2: begin r = p;   g = val; b = t;   end
            SECT_3: begin r = p;   g = q;   b = val; end
            SECT_4: begin r = t;   g = p;   b = val; end
            default: begin r = val; g = p;  b = q;   end
        endcase
        rgb.red = to_channel(r);
        rgb.green = to_channel(g);
        rgb.blue = to_channel(b);
        return rgb;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // check results against the oldest expectation, then queue the beat taken at this edge
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_rgb.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = pending_rgb.pop_front();
                    if (o_red !== want.red) report_mismatch("red", o_red, want.red);
                    if (o_green !== want.green) report_mismatch("green", o_green, want.green);
                    if (o_blue !== want.blue) report_mismatch("blue", o_blue, want.blue);
                end
            end
            if (start && !busy) begin
                pending_rgb.push_back(predict_rgb(i_hue, i_saturation, i_brightness));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_pixel(input t_fraction h, input t_fraction s, input t_fraction v);
        start <= 1'b1;
        i_hue <= h;
        i_saturation <= s;
        i_brightness <= v;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_fraction rand_fraction();
        t_fraction edges[6] = '{17'd0, 17'd1, 17'd65535, 17'd65536, 17'd65537, 17'h1FFFF};
        case ($urandom_range(0, 9))
            0: return edges[$urandom_range(0, 5)];
            1: return t_fraction'($urandom_range(0, 17'h1FFFF));
            default: return t_fraction'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic run_corner_pixels();
        send_pixel(17'd0, 17'd0, 17'd0);
        send_pixel(17'd65536, 17'd65536, 17'd65536);
        send_pixel(17'd65536, 17'd40000, 17'd50000);
        send_pixel(17'h1FFFF, 17'd30000, 17'd60000);
        send_pixel(17'd20000, 17'h1FFFF, 17'd65536);
        send_pixel(17'd45000, 17'd50000, 17'h1FFFF);
        send_pixel(17'd30000, 17'd0, 17'd33333);
        send_pixel(17'd65535, 17'd65535, 17'd65535);
        send_pixel(17'h10001, 17'h10001, 17'h10001);
        wait_for_drain();
    endtask

    task automatic run_sector_sweep();
        int unsigned first_hue;
        for (int k = 0; k < 6; k++) begin
            send_pixel(t_fraction'((k * 65536) / 6 + 5461), 17'd65536, 17'd65536);
        end
        for (int k = 1; k < 6; k++) begin
            first_hue = (k * 65536 + 5) / 6;
            send_pixel(t_fraction'(first_hue - 1), 17'd40000, 17'd60000);
            send_pixel(t_fraction'(first_hue), 17'd40000, 17'd60000);
        end
        wait_for_drain();
    endtask

    task automatic run_random_stream();
        int unsigned burst_left;
        burst_left = $urandom_range(1, 40);
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            send_pixel(rand_fraction(), rand_fraction(), rand_fraction());
            if (n == RANDOM_PIXELS / 2) begin
                wait_for_drain();
            end
            if (--burst_left == 0) begin
                hold_off($urandom_range(1, 6));
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                          : $urandom_range(1, 40);
            end
        end
        wait_for_drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_hue = '0;
        i_saturation = '0;
        i_brightness = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_corner_pixels();
        run_sector_sweep();
        run_random_stream();
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

### hsv_to_rgb_converter_unit.f
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsv_to_rgb_converter_unit.sv
tb/hsv_to_rgb_converter_unit_tb.sv
